// ===== rtl/assert_macros.svh =====
//------------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every enabled clock edge
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/opsfd_pkg.sv =====
//------------------------------------------------------------------------------
// opsfd_pkg
// Types and constants shared by the preamble/SFD trigger modules.
//------------------------------------------------------------------------------
`default_nettype none

package opsfd_pkg;

	localparam int SYMBOL_SAMPLES = 64;
	localparam int WIN_LEN        = 63;
	localparam int TAPS           = 32;
	localparam int NUM_SYMS       = 3;
	localparam int GROUPS         = 4;
	localparam int GROUP_TAPS     = 8;
	localparam int POWER_W        = 24;
	localparam int THR_W          = 16;
	localparam int RHS_W          = THR_W + POWER_W;
	localparam int LHS_SHIFT      = 8;
	localparam int QDEPTH         = 8;
	localparam int QPTR_W         = 3;
	localparam int QCNT_W         = 4;
	localparam int FRONT_CNT_W    = 3;
	localparam int APB_ADDR_W     = 2;
	localparam int APB_DATA_W     = 32;

	localparam logic [APB_ADDR_W-1:0] ADDR_THRESHOLD = '0;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd2048;

	// correlator rows
	localparam int SYM_ZERO  = 0;
	localparam int SYM_SEVEN = 1;
	localparam int SYM_A     = 2;

	// bit k set: tap k has coefficient sign -1
	localparam logic [TAPS-1:0] TAP_NEG [NUM_SYMS] = '{
		32'b0100_0010_0011_1111_0010_1101_1001_1100,
		32'b1100_0100_0010_0011_1111_0010_1101_1000,
		32'b0110_1010_0111_1000_1100_1001_0001_0111
	};

	typedef struct packed {
		logic zero;
		logic seven;
		logic sym_a;
	} flags_t;

endpackage

`default_nettype wire

// ===== rtl/opsfd_front.sv =====
//------------------------------------------------------------------------------
// opsfd_front
// Sample window, three-symbol correlators, magnitude and threshold test.
// Fixed four-stage pipeline; emits one flag set per accepted sample.
//------------------------------------------------------------------------------
`default_nettype none

module opsfd_front #(
	parameter int SAMPLE_WIDTH = 12
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    accept,
	input  wire logic signed [SAMPLE_WIDTH-1:0]          sample_i,
	input  wire logic signed [SAMPLE_WIDTH-1:0]          sample_q,
	input  wire logic [opsfd_pkg::POWER_W-1:0]           sample_power,
	input  wire logic [opsfd_pkg::THR_W-1:0]             threshold,
	output opsfd_pkg::flags_t                            flags,
	output logic                                         flags_valid,
	output logic [opsfd_pkg::FRONT_CNT_W-1:0]            inflight
);

	localparam int PW    = SAMPLE_WIDTH + 4;
	localparam int SW    = SAMPLE_WIDTH + 6;
	localparam int MAGW  = 2 * SAMPLE_WIDTH + 9;
	localparam int MSW   = MAGW + 1;
	localparam int LHSW  = MSW + opsfd_pkg::LHS_SHIFT;
	localparam int CMP_W = (LHSW > opsfd_pkg::RHS_W) ? LHSW : opsfd_pkg::RHS_W;

	logic signed [SAMPLE_WIDTH-1:0]    win_i_q [opsfd_pkg::WIN_LEN];
	logic signed [SAMPLE_WIDTH-1:0]    win_q_q [opsfd_pkg::WIN_LEN];
	logic [opsfd_pkg::POWER_W-1:0]     pow_q   [opsfd_pkg::WIN_LEN];
	logic                              v_s0_q;

	logic signed [PW-1:0] part_re [opsfd_pkg::NUM_SYMS][opsfd_pkg::GROUPS];
	logic signed [PW-1:0] part_im [opsfd_pkg::NUM_SYMS][opsfd_pkg::GROUPS];

	logic signed [PW-1:0]          part_re_s1 [opsfd_pkg::NUM_SYMS][opsfd_pkg::GROUPS];
	logic signed [PW-1:0]          part_im_s1 [opsfd_pkg::NUM_SYMS][opsfd_pkg::GROUPS];
	logic [opsfd_pkg::POWER_W-1:0] pow_s1;
	logic                          v_s1;

	logic signed [SW-1:0]          re_s2 [opsfd_pkg::NUM_SYMS];
	logic signed [SW-1:0]          im_s2 [opsfd_pkg::NUM_SYMS];
	logic [opsfd_pkg::POWER_W-1:0] pow_s2;
	logic                          v_s2;

	logic [MAGW-1:0]               sqre_s3 [opsfd_pkg::NUM_SYMS];
	logic [MAGW-1:0]               sqim_s3 [opsfd_pkg::NUM_SYMS];
	logic [opsfd_pkg::RHS_W-1:0]   rhs_s3;
	logic                          v_s3;

	logic [opsfd_pkg::NUM_SYMS-1:0] present;

	// sample window, index 0 oldest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < opsfd_pkg::WIN_LEN; n++) begin
				win_i_q[n] <= '0;
				win_q_q[n] <= '0;
				pow_q[n]   <= '0;
			end
			v_s0_q <= 1'b0;
		end else begin
			v_s0_q <= accept;
			if (accept) begin
				for (int n = 0; n < opsfd_pkg::WIN_LEN - 1; n++) begin
					win_i_q[n] <= win_i_q[n+1];
					win_q_q[n] <= win_q_q[n+1];
					pow_q[n]   <= pow_q[n+1];
				end
				win_i_q[opsfd_pkg::WIN_LEN-1] <= sample_i;
				win_q_q[opsfd_pkg::WIN_LEN-1] <= sample_q;
				pow_q[opsfd_pkg::WIN_LEN-1]   <= sample_power;
			end
		end
	end

	// partial correlations, eight taps per group
	always_comb begin
		logic signed [PW-1:0] ti, tq, cr, ci;
		for (int s = 0; s < opsfd_pkg::NUM_SYMS; s++) begin
			for (int g = 0; g < opsfd_pkg::GROUPS; g++) begin
				part_re[s][g] = '0;
				part_im[s][g] = '0;
				for (int j = 0; j < opsfd_pkg::GROUP_TAPS; j++) begin
					ti = PW'(win_i_q[2 * (opsfd_pkg::GROUP_TAPS * g + j)]);
					tq = PW'(win_q_q[2 * (opsfd_pkg::GROUP_TAPS * g + j)]);
					// +-1 taps on odd k, +-j taps on even k
					if ((j & 1) == 1) begin
						cr = ti;
						ci = tq;
					end else begin
						cr = -tq;
						ci = ti;
					end
					if (opsfd_pkg::TAP_NEG[s][opsfd_pkg::GROUP_TAPS * g + j]) begin
						cr = -cr;
						ci = -ci;
					end
					part_re[s][g] = part_re[s][g] + cr;
					part_im[s][g] = part_im[s][g] + ci;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= v_s0_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		part_re_s1 <= part_re;
		part_im_s1 <= part_im;
		pow_s1     <= pow_q[0];

		for (int s = 0; s < opsfd_pkg::NUM_SYMS; s++) begin
			re_s2[s] <= SW'(part_re_s1[s][0]) + SW'(part_re_s1[s][1])
				+ SW'(part_re_s1[s][2]) + SW'(part_re_s1[s][3]);
			im_s2[s] <= SW'(part_im_s1[s][0]) + SW'(part_im_s1[s][1])
				+ SW'(part_im_s1[s][2]) + SW'(part_im_s1[s][3]);
		end
		pow_s2 <= pow_s1;

		for (int s = 0; s < opsfd_pkg::NUM_SYMS; s++) begin
			sqre_s3[s] <= MAGW'($signed({{SW{re_s2[s][SW-1]}}, re_s2[s]})
				* $signed({{SW{re_s2[s][SW-1]}}, re_s2[s]}));
			sqim_s3[s] <= MAGW'($signed({{SW{im_s2[s][SW-1]}}, im_s2[s]})
				* $signed({{SW{im_s2[s][SW-1]}}, im_s2[s]}));
		end
		rhs_s3 <= opsfd_pkg::RHS_W'(threshold) * opsfd_pkg::RHS_W'(pow_s2);
	end

	// |corr|^2 * 256 > threshold * power
	always_comb begin
		logic [MSW-1:0] mag;
		for (int s = 0; s < opsfd_pkg::NUM_SYMS; s++) begin
			mag = MSW'(sqre_s3[s]) + MSW'(sqim_s3[s]);
			present[s] = CMP_W'({mag, {opsfd_pkg::LHS_SHIFT{1'b0}}}) > CMP_W'(rhs_s3);
		end
	end

	assign flags.zero  = present[opsfd_pkg::SYM_ZERO];
	assign flags.seven = present[opsfd_pkg::SYM_SEVEN];
	assign flags.sym_a = present[opsfd_pkg::SYM_A];
	assign flags_valid = v_s3;
	assign inflight    = opsfd_pkg::FRONT_CNT_W'(v_s0_q) + opsfd_pkg::FRONT_CNT_W'(v_s1)
		+ opsfd_pkg::FRONT_CNT_W'(v_s2) + opsfd_pkg::FRONT_CNT_W'(v_s3);

endmodule

`default_nettype wire

// ===== rtl/opsfd_fifo.sv =====
//------------------------------------------------------------------------------
// opsfd_fifo
// Small flag queue between the correlator front and the trigger back end.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module opsfd_fifo (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire opsfd_pkg::flags_t             push_data,
	input  wire logic                          pop,
	output opsfd_pkg::flags_t                  head,
	output logic                               empty,
	output logic [opsfd_pkg::QCNT_W-1:0]       count
);

	opsfd_pkg::flags_t                 mem_q [opsfd_pkg::QDEPTH];
	logic [opsfd_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [opsfd_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [opsfd_pkg::QCNT_W-1:0]      count_q;
	logic                              full;

	assign full  = (count_q == opsfd_pkg::QCNT_W'(opsfd_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	`ASSERT_AT(a_fifo_no_overflow, clk, arst_n, !(push && !pop && full), "flag queue overflow")
	`ASSERT_AT(a_fifo_no_underflow, clk, arst_n, !(pop && empty), "flag queue underflow")

endmodule

`default_nettype wire

// ===== rtl/opsfd_back.sv =====
//------------------------------------------------------------------------------
// opsfd_back
// Flag histories, trigger decision and output register.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module opsfd_back #(
	parameter int ZERO_SYMBOLS = 6
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire opsfd_pkg::flags_t  q_head,
	input  wire logic               q_empty,
	output logic                    q_pop,
	output logic                    trigger,
	output logic                    trigger_valid,
	input  wire logic               trigger_ready
);

	localparam int ZDEPTH = opsfd_pkg::SYMBOL_SAMPLES * (ZERO_SYMBOLS + 1);

	logic [ZDEPTH-1:0]                   zero_hist_q;
	logic [opsfd_pkg::SYMBOL_SAMPLES-1:0] seven_hist_q;
	logic                                out_valid_q;
	logic                                trigger_q;
	logic                                trig;

	assign q_pop = !q_empty && (!out_valid_q || trigger_ready);

	always_comb begin
		trig = q_head.sym_a && seven_hist_q[opsfd_pkg::SYMBOL_SAMPLES-1];
		for (int j = 2; j <= ZERO_SYMBOLS + 1; j++)
			trig = trig && zero_hist_q[opsfd_pkg::SYMBOL_SAMPLES * j - 1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_hist_q  <= '0;
			seven_hist_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				zero_hist_q  <= {zero_hist_q[ZDEPTH-2:0], q_head.zero};
				seven_hist_q <= {seven_hist_q[opsfd_pkg::SYMBOL_SAMPLES-2:0], q_head.seven};
				out_valid_q  <= 1'b1;
			end else if (trigger_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			trigger_q <= trig;
	end

	assign trigger       = trigger_q;
	assign trigger_valid = out_valid_q;

	`ASSERT_NEXT(a_back_pop_shows, clk, arst_n, q_pop, out_valid_q, "popped result not presented")

endmodule

`default_nettype wire

// ===== rtl/oqpsk_preamble_sfd_trigger.sv =====
//------------------------------------------------------------------------------
// oqpsk_preamble_sfd_trigger
// O-QPSK preamble and SFD trigger: correlates symbols 0, 7 and A over a
// 63-sample window and flags the zero-preamble, 7, A sequence.
//
// Usage:
//   Samples (sample_i, sample_q, sample_power) enter on the sample
//   valid/ready channel; each accepted sample yields exactly one trigger
//   bit on the trigger valid/ready channel, in order.
//   A sample passes the window, the correlator stages, the flag queue and
//   the output register before trigger_valid. Throughput: one sample per
//   cycle, sustained, while the trigger receiver keeps up.
//   The correlator pipeline never stalls; sample_ready drops once the
//   8-entry flag queue plus samples still in the pipeline reach 8, so a
//   stalled receiver backs up into sample_ready. The trigger output
//   register lets the next result move up in the same cycle as the
//   current one transfers. Reset clears the window, power line and flag
//   histories to zero and loads threshold with 2048; no clearing pass is
//   needed. The user writes threshold over APB (address 0) only while the
//   block is idle; the block itself does not enforce this.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module oqpsk_preamble_sfd_trigger #(
	parameter int SAMPLE_WIDTH = 12,
	parameter int ZERO_SYMBOLS = 6
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// APB configuration
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [opsfd_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [opsfd_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [opsfd_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                     pready,
	// sample channel
	input  wire logic                                sample_valid,
	output logic                                     sample_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_i,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_q,
	input  wire logic [opsfd_pkg::POWER_W-1:0]       sample_power,
	// trigger channel
	output logic                                     trigger_valid,
	input  wire logic                                trigger_ready,
	output logic                                     trigger
);

	localparam logic [opsfd_pkg::QCNT_W:0] QUEUE_CREDITS =
		(opsfd_pkg::QCNT_W+1)'(opsfd_pkg::QDEPTH);

	logic [opsfd_pkg::THR_W-1:0]        threshold_q;
	logic                               cfg_write;
	logic                               accept;
	opsfd_pkg::flags_t                  front_flags;
	logic                               front_valid;
	logic [opsfd_pkg::FRONT_CNT_W-1:0]  front_inflight;
	opsfd_pkg::flags_t                  q_head;
	logic                               q_empty;
	logic                               q_pop;
	logic [opsfd_pkg::QCNT_W-1:0]       q_count;
	logic [opsfd_pkg::QCNT_W:0]         occupancy;

	// single register at address 0
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready
		&& (paddr == opsfd_pkg::ADDR_THRESHOLD);
	assign prdata    = opsfd_pkg::APB_DATA_W'(threshold_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			threshold_q <= opsfd_pkg::THRESHOLD_RESET;
		else if (cfg_write)
			threshold_q <= pwdata[opsfd_pkg::THR_W-1:0];
	end

	assign occupancy    = (opsfd_pkg::QCNT_W+1)'(q_count)
		+ (opsfd_pkg::QCNT_W+1)'(front_inflight);
	assign sample_ready = (occupancy < QUEUE_CREDITS);
	assign accept       = sample_valid && sample_ready;

	opsfd_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.sample_i     (sample_i),
		.sample_q     (sample_q),
		.sample_power (sample_power),
		.threshold    (threshold_q),
		.flags        (front_flags),
		.flags_valid  (front_valid),
		.inflight     (front_inflight)
	);

	opsfd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_data (front_flags),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.count     (q_count)
	);

	opsfd_back #(
		.ZERO_SYMBOLS (ZERO_SYMBOLS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_head        (q_head),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.trigger       (trigger),
		.trigger_valid (trigger_valid),
		.trigger_ready (trigger_ready)
	);

	`ASSERT_AT(a_top_occupancy, clk, arst_n, occupancy <= QUEUE_CREDITS, "queue credit exceeded")

endmodule

`default_nettype wire

// ===== verif/oqpsk_trigger_checker.sv =====
//------------------------------------------------------------------------------
// oqpsk_trigger_checker
// Watches the APB port and both sample and trigger channels of the
// preamble/SFD trigger, keeps its own copy of the correlation window,
// power line, flag histories and threshold, predicts one trigger bit per
// sample transfer and compares each trigger transfer, in order, against it.
//------------------------------------------------------------------------------

package oqpsk_tb_pkg;

	localparam logic [opsfd_pkg::APB_ADDR_W-1:0] THRESHOLD_ADDR = '0;

	// bit k set: chip tap k of that symbol row is negative; row 0 is symbol 0
	localparam logic [2:0][31:0] SIGN_NEG = {
		32'h6A78C917,
		32'hC423F2D8,
		32'h423F2D9C
	};

endpackage

module oqpsk_trigger_checker #(
	parameter int SAMPLE_WIDTH = 12,
	parameter int ZERO_SYMBOLS = 6
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic                                  pready,
	input  logic [opsfd_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [opsfd_pkg::APB_DATA_W-1:0]      pwdata,
	input  logic                                  sample_valid,
	input  logic                                  sample_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample_i,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample_q,
	input  logic [opsfd_pkg::POWER_W-1:0]         sample_power,
	input  logic                                  trigger_valid,
	input  logic                                  trigger_ready,
	input  logic                                  trigger,
	output int                                    errors,
	output int                                    pending,
	output int                                    results_checked,
	output int                                    triggers_fired
);
	timeunit 1ns;
	timeprecision 1ps;

	import opsfd_pkg::*;
	import oqpsk_tb_pkg::*;

	localparam int ZERO_DEPTH  = SYMBOL_SAMPLES * (ZERO_SYMBOLS + 1);
	localparam int MAX_REPORTS = 10;

	typedef struct {
		bit fired;
		int index;
	} trig_expect_t;

	trig_expect_t expected_triggers [$];

	logic [THR_W-1:0]               threshold;
	logic signed [SAMPLE_WIDTH-1:0] win_i [WIN_LEN];
	logic signed [SAMPLE_WIDTH-1:0] win_q [WIN_LEN];
	logic [POWER_W-1:0]             win_pw [WIN_LEN];
	bit                             zero_seen [ZERO_DEPTH];
	bit                             seven_seen [SYMBOL_SAMPLES];
	int                             sample_count;

	// |corr|^2 * 256 > threshold * power of the oldest sample in the window
	function automatic bit sym_detected(input int row);
		longint re, im, s;
		longint unsigned mag;
		re = 0;
		im = 0;
		for (int k = 0; k < TAPS; k++) begin
			s = SIGN_NEG[row][k] ? -1 : 1;
			if ((k % 2) == 1) begin
				re += s * win_i[2*k];
				im += s * win_q[2*k];
			end else begin
				re -= s * win_q[2*k];
				im += s * win_i[2*k];
			end
		end
		mag = re * re + im * im;
		return (mag << LHS_SHIFT) > (64'(threshold) * 64'(win_pw[0]));
	endfunction

	function automatic void log_failure(input string what);
		if (errors < MAX_REPORTS)
			$display("ERROR: %s", what);
		errors++;
	endfunction

	always @(posedge clk) begin : track
		trig_expect_t head;
		bit hit_zero, hit_seven, hit_a, fire;
		if (!arst_n) begin
			threshold = THRESHOLD_RESET;
			for (int n = 0; n < WIN_LEN; n++) begin
				win_i[n] = '0;
				win_q[n] = '0;
				win_pw[n] = '0;
			end
			for (int n = 0; n < ZERO_DEPTH; n++)
				zero_seen[n] = 1'b0;
			for (int n = 0; n < SYMBOL_SAMPLES; n++)
				seven_seen[n] = 1'b0;
			expected_triggers.delete();
			errors = 0;
			results_checked = 0;
			triggers_fired = 0;
			sample_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == THRESHOLD_ADDR)
				threshold = pwdata[THR_W-1:0];

			if (trigger_valid && trigger_ready) begin
				if (expected_triggers.size() == 0) begin
					log_failure($sformatf("trigger transfer %0b with no sample pending",
						trigger));
				end else begin
					head = expected_triggers.pop_front();
					results_checked++;
					if (trigger !== head.fired)
						log_failure($sformatf("sample %0d: trigger expected %0b, got %0b",
							head.index, head.fired, trigger));
				end
				if (trigger === 1'b1)
					triggers_fired++;
			end

			if (sample_valid && sample_ready) begin
				for (int n = 0; n < WIN_LEN - 1; n++) begin
					win_i[n] = win_i[n+1];
					win_q[n] = win_q[n+1];
					win_pw[n] = win_pw[n+1];
				end
				win_i[WIN_LEN-1] = sample_i;
				win_q[WIN_LEN-1] = sample_q;
				win_pw[WIN_LEN-1] = sample_power;

				hit_zero = sym_detected(SYM_ZERO);
				hit_seven = sym_detected(SYM_SEVEN);
				hit_a = sym_detected(SYM_A);

				fire = hit_a && seven_seen[SYMBOL_SAMPLES-1];
				for (int j = 2; j <= ZERO_SYMBOLS + 1; j++)
					if (!zero_seen[SYMBOL_SAMPLES*j-1])
						fire = 1'b0;

				for (int n = ZERO_DEPTH - 1; n > 0; n--)
					zero_seen[n] = zero_seen[n-1];
				for (int n = SYMBOL_SAMPLES - 1; n > 0; n--)
					seven_seen[n] = seven_seen[n-1];
				zero_seen[0] = hit_zero;
				seven_seen[0] = hit_seven;

				expected_triggers.push_back('{fired: fire, index: sample_count});
				sample_count++;
			end
		end
		pending = expected_triggers.size();
	end

endmodule

// ===== verif/testbench.sv =====
//------------------------------------------------------------------------------
// testbench
// Drives samples into the preamble/SFD trigger: corner values first, then
// chip-pattern symbols, a full zero-preamble/7/A sequence and noise, under
// several thresholds, with random gaps on both channels and a long
// receiver stall. Checking is done by oqpsk_trigger_checker.
//------------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import opsfd_pkg::*;
	import oqpsk_tb_pkg::*;

	localparam int SW           = 12;
	localparam int ZS           = 6;
	localparam int RST_CYCLES   = 10;
	localparam int LONG_HOLD    = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int NOISE_SYM    = 3;

	typedef enum int {LEAD_NONE, LEAD_CLEAN, LEAD_BROKEN} lead_e;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_W-1:0]    paddr;
	logic [APB_DATA_W-1:0]    pwdata;
	logic [APB_DATA_W-1:0]    prdata;
	logic                     pready;
	logic                     sample_valid;
	logic                     sample_ready;
	logic signed [SW-1:0]     sample_i;
	logic signed [SW-1:0]     sample_q;
	logic [POWER_W-1:0]       sample_power;
	logic                     trigger_valid;
	logic                     trigger_ready;
	logic                     trigger;

	int errors;
	int pending;
	int results_checked;
	int triggers_fired;

	bit tx_throttle;
	bit rx_throttle;
	bit rx_hold;
	int sent;
	int settings;
	int stall_cycles;

	oqpsk_preamble_sfd_trigger #(
		.SAMPLE_WIDTH(SW),
		.ZERO_SYMBOLS(ZS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_i(sample_i),
		.sample_q(sample_q),
		.sample_power(sample_power),
		.trigger_valid(trigger_valid),
		.trigger_ready(trigger_ready),
		.trigger(trigger)
	);

	oqpsk_trigger_checker #(
		.SAMPLE_WIDTH(SW),
		.ZERO_SYMBOLS(ZS)
	) trigger_check (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 3);
	endfunction

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (trigger_valid && trigger_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("oqpsk_preamble_sfd_trigger test failed");
			$finish;
		end
	end

	initial begin : trigger_sink
		trigger_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				rx_hold = 1'b0;
				trigger_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				trigger_ready <= 1'b1;
			end else if (rx_throttle && $urandom_range(0, 3) == 0) begin
				trigger_ready <= 1'b0;
				repeat (idle_len()) @(negedge clk);
				trigger_ready <= 1'b1;
			end else
				trigger_ready <= 1'b1;
		end
	end

	// called and returns at a falling edge
	task automatic send_sample(input logic signed [SW-1:0] si, input logic signed [SW-1:0] sq,
		input logic [POWER_W-1:0] pw);
		if (tx_throttle && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat (idle_len()) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample_i <= si;
		sample_q <= sq;
		sample_power <= pw;
		do
			@(posedge clk);
		while (!sample_ready);
		sent++;
		@(negedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= THRESHOLD_ADDR;
		pwdata <= APB_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings++;
	endtask

	task automatic wait_idle();
		sample_valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	// one 64-sample symbol at two samples per chip; even samples carry the
	// chips, rotated onto the real or imaginary axis of the correlation
	task automatic send_symbol(input int kind, input int amp, input int rot,
		input logic [POWER_W-1:0] pw_base);
		int c, k, si, sq;
		logic [POWER_W-1:0] pw;
		for (int n = 0; n < SYMBOL_SAMPLES; n++) begin
			k = n / 2;
			if (kind == NOISE_SYM || (n % 2) == 1) begin
				si = int'($urandom_range(0, 2 * amp)) - amp;
				sq = int'($urandom_range(0, 2 * amp)) - amp;
			end else begin
				c = SIGN_NEG[kind][k] ? -amp : amp;
				if (rot == 0) begin
					si = ((k % 2) == 1) ? c : 0;
					sq = ((k % 2) == 1) ? 0 : -c;
				end else begin
					si = ((k % 2) == 1) ? 0 : c;
					sq = ((k % 2) == 1) ? c : 0;
				end
				si += int'($urandom_range(0, 62)) - 31;
				sq += int'($urandom_range(0, 62)) - 31;
			end
			pw = ($urandom_range(0, 15) == 0) ? '0 : POWER_W'(pw_base + $urandom_range(0, 255));
			send_sample(SW'(si), SW'(sq), pw);
		end
	endtask

	// six zero symbols, then 7, then A; a broken sequence has one symbol swapped
	task automatic send_preamble(input bit broken);
		int kinds [ZS+2];
		int amp, rot, idx;
		logic [POWER_W-1:0] pw;
		for (int s = 0; s < ZS + 2; s++)
			kinds[s] = (s < ZS) ? SYM_ZERO : ((s == ZS) ? SYM_SEVEN : SYM_A);
		if (broken) begin
			idx = $urandom_range(0, ZS + 1);
			kinds[idx] = (kinds[idx] + $urandom_range(1, NOISE_SYM)) % (NOISE_SYM + 1);
		end
		amp = $urandom_range(300, 2000);
		rot = $urandom_range(0, 1);
		pw = POWER_W'($urandom_range(0, 24'h3FFFFF));
		for (int s = 0; s < ZS + 2; s++) begin
			tx_throttle = $urandom_range(0, 2) == 0;
			rx_throttle = $urandom_range(0, 2) == 0;
			if (s == 2) begin
				tx_throttle = 1'b0;
				rx_hold = 1'b1;
			end
			send_symbol(kinds[s], amp, rot, pw);
		end
	endtask

	task automatic run_phase(input logic [THR_W-1:0] thr, input int budget, input lead_e lead);
		int n, len;
		n = 0;
		wait_idle();
		write_threshold(thr);
		if (lead != LEAD_NONE) begin
			send_preamble(lead == LEAD_BROKEN);
			n += (ZS + 2) * SYMBOL_SAMPLES;
		end
		while (n < budget) begin
			tx_throttle = $urandom_range(0, 2) != 0;
			rx_throttle = $urandom_range(0, 2) != 0;
			if ($urandom_range(0, 2) != 0) begin
				send_symbol($urandom_range(SYM_ZERO, NOISE_SYM), $urandom_range(300, 2000),
					$urandom_range(0, 1), POWER_W'($urandom));
				n += SYMBOL_SAMPLES;
			end else begin
				len = $urandom_range(8, 40);
				repeat (len) send_sample(SW'($urandom), SW'($urandom), POWER_W'($urandom));
				n += len;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_valid = 1'b0;
		sample_i = '0;
		sample_q = '0;
		sample_power = '0;
		tx_throttle = 1'b0;
		rx_throttle = 1'b0;
		rx_hold = 1'b0;
		sent = 0;
		settings = 1;
		stall_cycles = 0;
		repeat (RST_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// corners at the reset threshold; the window still holds zero power
		send_sample(12'h800, 12'h800, 24'hFFFFFF);
		send_sample(12'h7FF, 12'h7FF, 24'h000000);
		send_sample(12'h800, 12'h7FF, 24'h000000);
		send_sample(12'h7FF, 12'h800, 24'hFFFFFF);
		send_sample(12'h000, 12'h000, 24'h000000);
		send_sample(12'hFFF, 12'h001, 24'h000001);
		send_sample(12'h001, 12'hFFF, 24'h800000);
		send_sample(12'h555, 12'hAAA, 24'h555555);
		send_sample(12'hAAA, 12'h555, 24'hAAAAAA);
		repeat (15)
			send_sample($urandom_range(0, 1) ? 12'h7FF : 12'h800,
				$urandom_range(0, 1) ? 12'h7FF : 12'h800,
				$urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000);

		run_phase(16'hFFFF, 40, LEAD_NONE);
		run_phase(THRESHOLD_RESET, 1, LEAD_CLEAN);
		run_phase(16'h0000, 40, LEAD_NONE);
		run_phase(THR_W'($urandom_range(256, 8192)), 40, LEAD_NONE);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d samples over %0d threshold settings (0 and 65535 among them),",
			sent, settings);
		$display("%0d trigger transfers checked, %0d of them set", results_checked,
			triggers_fired);
		if (errors == 0 && pending == 0)
			$display("oqpsk_preamble_sfd_trigger test passed");
		else
			$display("oqpsk_preamble_sfd_trigger test failed");
		$finish;
	end

endmodule
